// File: hw/rtl/lec_pkg.sv
package lec_pkg;

  localparam logic [7:0] CH_LF  = 8'd10;
  localparam logic [7:0] CH_CR  = 8'd13;
  localparam logic [7:0] CH_SUB = 8'd26;
  localparam logic [7:0] CH_RS  = 8'd30;

  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    MODE_DOS_UNIX = 2'd0,
    MODE_DOS_REC  = 2'd1,
    MODE_UNIX_DOS = 2'd2,
    MODE_PASS     = 2'd3
  } mode_t;

  // one or two results caused by a single input byte
  typedef struct packed {
    logic       two;
    logic [7:0] b0;
    logic       v0;
    logic [7:0] b1;
    logic       send;
  } lec_entry_t;

endpackage

// File: hw/rtl/line_ending_converter.sv
// Channel | Dir | Ports                          | Content
// in_     | in  | tvalid tready tdata tlast      | raw byte, last byte of stream
// out_    | out | tvalid tready tdata tuser tlast| converted byte, flags, run end
// cfg_    | in  | wr_en wr_data                  | conversion mode
//
// One input byte per cycle while the queue has room; a byte that expands to
// two results (CR LF, or a held CR ahead of another byte) gives two output
// transfers, the second from a pending register. Input passes through the
// queue and the output register. Reset clears the mode to record form and
// the CR state. Either side may stall; the queue absorbs the difference.
module line_ending_converter #(
  parameter int unsigned QUEUE_DEPTH = lec_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_wr_data,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic [1:0] out_tuser,  // [0] byte_valid, [1] stream_end
  output logic       out_tlast
);
  import lec_pkg::*;

  logic       push_valid, push_ready, pop_valid, pop_ready;
  lec_entry_t push_data, pop_data;

  lec_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_byte    (in_tdata),
    .in_last    (in_tlast),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  lec_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data)
  );

  lec_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

endmodule

// File: hw/rtl/lec_front.sv
module lec_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [1:0]          cfg_wr_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_byte,
  input  logic                in_last,
  output logic                push_valid,
  input  logic                push_ready,
  output lec_pkg::lec_entry_t push_data
);
  import lec_pkg::*;

  mode_t      mode_r;
  logic       held_cr_r, held_cr_nxt;
  logic       stopped_r, stopped_nxt;
  logic [1:0] n;
  logic [7:0] bb0, bb1;
  logic       accept;

  assign in_ready = push_ready;
  assign accept   = in_valid && push_ready;

  always_comb begin
    n           = 2'd0;
    bb0         = 8'h00;
    bb1         = 8'h00;
    held_cr_nxt = held_cr_r;
    stopped_nxt = stopped_r;
    if (stopped_r) begin
      n = 2'd0;
    end else if (mode_r == MODE_PASS) begin
      if (held_cr_r) begin
        bb0 = CH_CR;
        bb1 = in_byte;
        n   = 2'd2;
      end else begin
        bb0 = in_byte;
        n   = 2'd1;
      end
      held_cr_nxt = 1'b0;
    end else if (in_byte == CH_CR) begin
      if (held_cr_r) begin
        bb0 = CH_CR;
        n   = 2'd1;
      end
      held_cr_nxt = 1'b1;
    end else if (in_byte == CH_LF) begin
      if (mode_r == MODE_UNIX_DOS) begin
        bb0 = CH_CR;
        bb1 = CH_LF;
        n   = 2'd2;
      end else if (held_cr_r) begin
        bb0 = (mode_r == MODE_DOS_REC) ? CH_RS : CH_LF;
        n   = 2'd1;
      end else begin
        bb0 = CH_LF;
        n   = 2'd1;
      end
      held_cr_nxt = 1'b0;
    end else if (in_byte == CH_SUB && mode_r != MODE_UNIX_DOS) begin
      if (held_cr_r) begin
        bb0 = CH_CR;
        n   = 2'd1;
      end
      held_cr_nxt = 1'b0;
      if (mode_r == MODE_DOS_REC) begin
        stopped_nxt = 1'b1;
      end else if (!in_last) begin
        if (n == 2'd0) begin
          bb0 = CH_SUB;
        end else begin
          bb1 = CH_SUB;
        end
        n = n + 2'd1;
      end
    end else begin
      if (held_cr_r) begin
        bb0 = CH_CR;
        bb1 = in_byte;
        n   = 2'd2;
      end else begin
        bb0 = in_byte;
        n   = 2'd1;
      end
      held_cr_nxt = 1'b0;
    end

    // flush a held CR at stream end
    if (in_last && held_cr_nxt && n != 2'd2) begin
      if (n == 2'd0) begin
        bb0 = CH_CR;
      end else begin
        bb1 = CH_CR;
      end
      n = n + 2'd1;
    end
    if (in_last) begin
      held_cr_nxt = 1'b0;
      stopped_nxt = 1'b0;
    end
  end

  always_comb begin
    push_valid     = accept && (n != 2'd0 || in_last);
    push_data.two  = (n == 2'd2);
    push_data.b0   = bb0;
    push_data.v0   = (n != 2'd0);
    push_data.b1   = bb1;
    push_data.send = in_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_DOS_REC;
      held_cr_r <= 1'b0;
      stopped_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        mode_r <= mode_t'(cfg_wr_data);
      end
      if (accept) begin
        held_cr_r <= held_cr_nxt;
        stopped_r <= stopped_nxt;
      end
    end
  end

endmodule

// File: hw/rtl/lec_fifo.sv
module lec_fifo #(
  parameter int unsigned DEPTH = lec_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  output logic                push_ready,
  input  lec_pkg::lec_entry_t push_data,
  output logic                pop_valid,
  input  logic                pop_ready,
  output lec_pkg::lec_entry_t pop_data
);
  import lec_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  lec_entry_t    mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push, do_pop;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (do_pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// File: hw/rtl/lec_back.sv
module lec_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                pop_valid,
  output logic                pop_ready,
  input  lec_pkg::lec_entry_t pop_data,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [7:0]          out_tdata,
  output logic [1:0]          out_tuser,
  output logic                out_tlast
);
  import lec_pkg::*;

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic       out_bv_r, out_bv_nxt;
  logic       out_last_r, out_last_nxt;
  logic       out_send_r, out_send_nxt;
  logic       pend_r, pend_nxt;
  logic [7:0] pend_byte_r, pend_byte_nxt;
  logic       pend_send_r, pend_send_nxt;
  logic       load;

  assign load      = !out_valid_r || out_tready;
  assign pop_ready = load && !pend_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_bv_nxt    = out_bv_r;
    out_last_nxt  = out_last_r;
    out_send_nxt  = out_send_r;
    pend_nxt      = pend_r;
    pend_byte_nxt = pend_byte_r;
    pend_send_nxt = pend_send_r;
    if (load) begin
      if (pend_r) begin
        out_valid_nxt = 1'b1;
        out_byte_nxt  = pend_byte_r;
        out_bv_nxt    = 1'b1;
        out_last_nxt  = 1'b1;
        out_send_nxt  = pend_send_r;
        pend_nxt      = 1'b0;
      end else if (pop_valid) begin
        out_valid_nxt = 1'b1;
        out_byte_nxt  = pop_data.b0;
        out_bv_nxt    = pop_data.v0;
        out_last_nxt  = !pop_data.two;
        out_send_nxt  = pop_data.send && !pop_data.two;
        pend_nxt      = pop_data.two;
        pend_byte_nxt = pop_data.b1;
        pend_send_nxt = pop_data.send;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r  <= out_byte_nxt;
    out_bv_r    <= out_bv_nxt;
    out_last_r  <= out_last_nxt;
    out_send_r  <= out_send_nxt;
    pend_byte_r <= pend_byte_nxt;
    pend_send_r <= pend_send_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = {out_send_r, out_bv_r};
  assign out_tlast  = out_last_r;

endmodule

// File: hw/rtl/lec_checker.sv
module lec_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic [1:0] out_tuser,
  input logic       out_tlast
);

  a_send_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tlast)
    else $error("stream end without run end");

  a_marker_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tuser[1] && out_tlast && out_tdata == 8'h00)
    else $error("malformed end marker");

  a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled transaction changed");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind line_ending_converter lec_checker u_lec_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser),
  .out_tlast (out_tlast)
);

// File: tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import lec_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       run_end;
    logic       strm_end;
  } out_rec_t;

  typedef struct {
    mode_t      md;
    logic [7:0] b;
    logic       l;
    logic       fixed;
    out_rec_t   want;
  } row_t;

  localparam out_rec_t NO_OUT = '0;
  localparam int NROWS = 26;
  localparam int RANDOM_ITEMS = 425;
  localparam int STALL_LIMIT = 3000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_wr_en = 1'b0;
  logic [1:0] cfg_wr_data = '0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = '0;   // [7:0] in_byte
  logic       in_tlast = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;       // [7:0] out_byte
  logic [1:0] out_tuser;       // [0] byte_valid, [1] stream_end
  logic       out_tlast;

  // converter state as seen from outside
  mode_t cur_mode = MODE_DOS_REC;
  logic  pend_cr = 1'b0;
  logic  halted = 1'b0;

  out_rec_t pending_out[$];
  int mism = 0;
  int bytes_in = 0;
  int streams_in = 0;
  int bytes_out = 0;
  int idle_cyc = 0;
  int hold_left = 0;
  logic tx_calm = 1'b0;
  logic rx_calm = 1'b0;
  logic squeeze = 1'b0;
  logic hold_done = 1'b0;
  row_t dir_rows [NROWS];

  line_ending_converter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int convert_byte(input logic [7:0] b, input logic l,
                                      output out_rec_t res [2]);
    logic [7:0] ob [2];
    int n;
    n = 0;
    res[0] = NO_OUT;
    res[1] = NO_OUT;
    ob[0] = '0;
    ob[1] = '0;
    if (halted) begin
    end else if (cur_mode == MODE_PASS) begin
      if (pend_cr) begin
        ob[n] = CH_CR; n++; pend_cr = 1'b0;
      end
      ob[n] = b; n++;
    end else if (b == CH_CR) begin
      if (pend_cr) begin
        ob[n] = CH_CR; n++;
      end
      pend_cr = 1'b1;
    end else if (b == CH_LF) begin
      if (cur_mode == MODE_UNIX_DOS) begin
        ob[0] = CH_CR; ob[1] = CH_LF; n = 2;
      end else if (pend_cr) begin
        ob[n] = (cur_mode == MODE_DOS_REC) ? CH_RS : CH_LF; n++;
      end else begin
        ob[n] = CH_LF; n++;
      end
      pend_cr = 1'b0;
    end else if (b == CH_SUB && cur_mode != MODE_UNIX_DOS) begin
      if (pend_cr) begin
        ob[n] = CH_CR; n++; pend_cr = 1'b0;
      end
      if (cur_mode == MODE_DOS_REC) halted = 1'b1;
      else if (!l) begin
        ob[n] = CH_SUB; n++;
      end
    end else begin
      if (pend_cr) begin
        ob[n] = CH_CR; n++; pend_cr = 1'b0;
      end
      ob[n] = b; n++;
    end
    if (l && pend_cr && n < 2) begin
      ob[n] = CH_CR; n++; pend_cr = 1'b0;
    end
    for (int k = 0; k < n; k++) res[k] = '{ob[k], 1'b1, 1'b0, 1'b0};
    if (l) begin
      if (n == 0) n = 1;
      res[n-1].strm_end = 1'b1;
      pend_cr = 1'b0;
      halted = 1'b0;
    end
    if (n > 0) res[n-1].run_end = 1'b1;
    return n;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic l, input logic fixed,
                           input out_rec_t want);
    out_rec_t res [2];
    int n;
    while (!tx_calm && $urandom_range(99) < 27) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= l;
    do @(posedge clk); while (!in_tready);
    n = convert_byte(b, l, res);
    if (fixed) pending_out.push_back(want);
    else for (int k = 0; k < n; k++) pending_out.push_back(res[k]);
    bytes_in++;
    if (l) streams_in++;
  endtask

  task automatic set_mode(input mode_t m);
    in_tvalid <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_mode = m;
  endtask

  // receiver: random backpressure, one long hold-off, checking
  always @(posedge clk) begin
    out_rec_t got;
    out_rec_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tdata, out_tuser[0], out_tlast, out_tuser[1]};
      bytes_out++;
      if (pending_out.size() == 0) begin
        mism++;
        if (mism <= 10)
          $display("unexpected transaction: byte %h valid %b run_end %b stream_end %b",
                   got.data, got.valid, got.run_end, got.strm_end);
      end else begin
        want = pending_out.pop_front();
        if (got !== want) begin
          mism++;
          if (mism <= 10)
            $display({"mismatch: expected byte %h valid %b run_end %b stream_end %b,",
                      " got byte %h valid %b run_end %b stream_end %b"},
                     want.data, want.valid, want.run_end, want.strm_end,
                     got.data, got.valid, got.run_end, got.strm_end);
        end
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (squeeze && !hold_done) begin
      hold_left = 150;
      hold_done <= 1'b1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= rx_calm || ($urandom_range(99) >= 27);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cyc <= 0;
    else idle_cyc <= idle_cyc + 1;
    if (idle_cyc >= STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    logic [7:0] b;
    logic l;
    int r;
    int phase;
    int plen;
    int done_rand;
    dir_rows = '{
      '{MODE_DOS_REC,  8'h00,  1'b0, 1'b1, '{8'h00, 1'b1, 1'b1, 1'b0}},
      '{MODE_DOS_REC,  CH_CR,  1'b0, 1'b0, NO_OUT},
      '{MODE_DOS_REC,  CH_LF,  1'b0, 1'b0, NO_OUT},
      '{MODE_DOS_REC,  CH_CR,  1'b0, 1'b0, NO_OUT},
      '{MODE_DOS_REC,  CH_CR,  1'b0, 1'b0, NO_OUT},
      '{MODE_DOS_REC,  8'h41,  1'b0, 1'b0, NO_OUT},
      '{MODE_DOS_REC,  CH_LF,  1'b0, 1'b0, NO_OUT},
      '{MODE_DOS_REC,  CH_SUB, 1'b0, 1'b0, NO_OUT},
      '{MODE_DOS_REC,  8'h55,  1'b0, 1'b0, NO_OUT},
      '{MODE_DOS_REC,  CH_CR,  1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1}},
      '{MODE_DOS_REC,  CH_CR,  1'b1, 1'b0, NO_OUT},
      '{MODE_DOS_UNIX, CH_CR,  1'b0, 1'b0, NO_OUT},
      '{MODE_DOS_UNIX, CH_LF,  1'b0, 1'b0, NO_OUT},
      '{MODE_DOS_UNIX, CH_SUB, 1'b0, 1'b0, NO_OUT},
      '{MODE_DOS_UNIX, CH_CR,  1'b0, 1'b0, NO_OUT},
      '{MODE_DOS_UNIX, CH_SUB, 1'b1, 1'b0, NO_OUT},
      '{MODE_DOS_UNIX, 8'hFF,  1'b1, 1'b1, '{8'hFF, 1'b1, 1'b1, 1'b1}},
      '{MODE_UNIX_DOS, CH_LF,  1'b0, 1'b0, NO_OUT},
      '{MODE_UNIX_DOS, CH_CR,  1'b0, 1'b0, NO_OUT},
      '{MODE_UNIX_DOS, CH_LF,  1'b0, 1'b0, NO_OUT},
      '{MODE_UNIX_DOS, CH_SUB, 1'b0, 1'b0, NO_OUT},
      '{MODE_UNIX_DOS, CH_CR,  1'b0, 1'b0, NO_OUT},
      '{MODE_UNIX_DOS, CH_CR,  1'b1, 1'b0, NO_OUT},
      '{MODE_UNIX_DOS, CH_CR,  1'b0, 1'b0, NO_OUT},
      '{MODE_PASS,     CH_CR,  1'b0, 1'b0, NO_OUT},
      '{MODE_PASS,     8'h80,  1'b1, 1'b0, NO_OUT}
    };
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < NROWS; i++) begin
      if (dir_rows[i].md != cur_mode) set_mode(dir_rows[i].md);
      send_byte(dir_rows[i].b, dir_rows[i].l, dir_rows[i].fixed, dir_rows[i].want);
    end

    // random streams; a phase may end mid-stream, carrying CR and stop state over
    done_rand = 0;
    phase = 0;
    while (done_rand < RANDOM_ITEMS) begin
      set_mode((phase < 4) ? mode_t'(phase[1:0]) : mode_t'($urandom_range(3)));
      tx_calm = (phase == 1) || (phase == 2);
      rx_calm = (phase == 1);
      squeeze = (phase == 2);
      plen = $urandom_range(30, 70);
      for (int j = 0; j < plen && done_rand < RANDOM_ITEMS; j++) begin
        r = $urandom_range(99);
        if (r < 15) b = CH_CR;
        else if (r < 30) b = CH_LF;
        else if (r < 38) b = CH_SUB;
        else if (r < 42) b = CH_RS;
        else b = 8'($urandom_range(255));
        l = ($urandom_range(15) == 0);
        send_byte(b, l, 1'b0, NO_OUT);
        done_rand++;
      end
      phase++;
    end
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    squeeze = 1'b0;

    in_tvalid <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("%0d input bytes in %0d complete streams, %0d output transactions checked",
             bytes_in, streams_in, bytes_out);
    $display("all four modes, mode change with a CR held, long output hold-off, %0d mismatches",
             mism);
    if (mism == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
